// ===== hdl/inv3_pkg.sv =====
// Types and constants shared by the 3x3 matrix inverse pipeline.
package inv3_pkg;

  localparam int unsigned NDIV = 18;  // quotient bits, two above the 16-bit result
  localparam int unsigned DETW = 51;
  localparam int unsigned REMW = 48;
  localparam int unsigned CMPW = DETW + NDIV + 1;

  localparam logic [31:0] THR_RESET = 32'd167;

  typedef struct packed {
    logic signed [15:0] a11;
    logic signed [15:0] a12;
    logic signed [15:0] a13;
    logic signed [15:0] a21;
    logic signed [15:0] a22;
    logic signed [15:0] a23;
    logic signed [15:0] a31;
    logic signed [15:0] a32;
    logic signed [15:0] a33;
  } in_t;

  typedef struct packed {
    logic signed [15:0] b11;
    logic signed [15:0] b12;
    logic signed [15:0] b13;
    logic signed [15:0] b21;
    logic signed [15:0] b22;
    logic signed [15:0] b23;
    logic signed [15:0] b31;
    logic signed [15:0] b32;
    logic signed [15:0] b33;
    logic               singular;
    logic               clipped;
  } out_t;

  typedef struct packed {
    logic [8:0][REMW-1:0] rem;
    logic [8:0][NDIV-1:0] quo;
    logic [8:0]           neg;
    logic [DETW-1:0]      dmag;
    logic                 sing;
  } div_t;

  // Operand indexes of the cofactor products: adj[i] = P[2i] - P[2i+1].
  localparam logic [3:0] PA [18] = '{4'd4, 4'd5, 4'd2, 4'd1, 4'd1, 4'd2,
                                     4'd5, 4'd3, 4'd0, 4'd2, 4'd2, 4'd0,
                                     4'd3, 4'd4, 4'd1, 4'd0, 4'd0, 4'd1};
  localparam logic [3:0] PB [18] = '{4'd8, 4'd7, 4'd7, 4'd8, 4'd5, 4'd4,
                                     4'd6, 4'd8, 4'd8, 4'd6, 4'd3, 4'd5,
                                     4'd7, 4'd6, 4'd6, 4'd7, 4'd4, 4'd3};

endpackage

// ===== hdl/invert_3x3_matrix.sv =====
// 3x3 matrix inverse by adjugate, fully pipelined with restoring division.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall  | in_data  (nine Q8.8 elements)
//   out     | output    | out_valid/out_stall| out_data (nine Q8.8, flags)
//   cfg     | input     | cfg_valid/cfg_ready| cfg_data (singular threshold)
//
// One item per cycle unless stalled; stages: products, cofactors, determinant
// products, determinant sum, magnitudes, 18 restoring divider stages (one
// quotient bit each, nine lanes), saturation. The divider sets the depth.
// Reset (rst_n, synchronous) empties the pipeline and loads threshold 167.
// A stall at the output holds only the stages that are full; bubbles close up.
module invert_3x3_matrix (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  inv3_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output inv3_pkg::out_t  out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [31:0]     cfg_data
);
  import inv3_pkg::*;

  localparam int unsigned NST = 6 + NDIV;

  logic [31:0]            thr_r;
  logic [NST-1:0]         v_r;
  logic [NST-1:0]         en;

  logic signed [15:0]     m [9];
  logic signed [31:0]     prod_r [18];
  logic signed [15:0]     top0_r [3];
  logic signed [32:0]     adj1_r [9];
  logic signed [15:0]     top1_r [3];
  logic signed [48:0]     dp_r [3];
  logic signed [32:0]     adj2_r [9];
  logic signed [DETW-1:0] det_r;
  logic signed [32:0]     adj3_r [9];
  div_t                   dv_r [NDIV+1];
  div_t                   dv_nxt [NDIV+1];
  out_t                   out_r;
  out_t                   out_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      thr_r <= cfg_data;
    end
  end

  // A stage takes a new item when it is empty or its item moves on.
  always_comb begin
    en[NST-1] = !v_r[NST-1] || !out_stall;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = v_r[NST-1];
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  always_comb begin
    m[0] = in_data.a11;  m[1] = in_data.a12;  m[2] = in_data.a13;
    m[3] = in_data.a21;  m[4] = in_data.a22;  m[5] = in_data.a23;
    m[6] = in_data.a31;  m[7] = in_data.a32;  m[8] = in_data.a33;
  end

  // Front end: products, cofactors, determinant.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < 18; i++) begin
        prod_r[i] <= m[PA[i]] * m[PB[i]];
      end
      for (int i = 0; i < 3; i++) begin
        top0_r[i] <= m[i];
      end
    end
    if (en[1]) begin
      for (int i = 0; i < 9; i++) begin
        adj1_r[i] <= 33'(prod_r[2*i]) - 33'(prod_r[2*i+1]);
      end
      top1_r <= top0_r;
    end
    if (en[2]) begin
      dp_r[0] <= 49'(top1_r[0]) * 49'(adj1_r[0]);
      dp_r[1] <= 49'(top1_r[1]) * 49'(adj1_r[3]);
      dp_r[2] <= 49'(top1_r[2]) * 49'(adj1_r[6]);
      adj2_r  <= adj1_r;
    end
    if (en[3]) begin
      det_r  <= DETW'(dp_r[0]) + DETW'(dp_r[1]) + DETW'(dp_r[2]);
      adj3_r <= adj2_r;
    end
  end

  // Magnitudes and signs, then one quotient bit per stage.
  always_comb begin
    logic [DETW-1:0] dm;
    logic [32:0]     am;
    logic [CMPW-1:0] dsh;
    dm = det_r[DETW-1] ? DETW'(-det_r) : DETW'(det_r);
    dv_nxt[0].dmag = dm;
    dv_nxt[0].sing = ({19'd0, thr_r} >= {1'b0, dm[DETW-2:0]});
    for (int i = 0; i < 9; i++) begin
      am = adj3_r[i][32] ? 33'(-adj3_r[i]) : 33'(adj3_r[i]);
      dv_nxt[0].rem[i] = {am[31:0], 16'd0};
      dv_nxt[0].quo[i] = '0;
      dv_nxt[0].neg[i] = adj3_r[i][32] ^ det_r[DETW-1];
    end
    for (int s = 0; s < NDIV; s++) begin
      dv_nxt[s+1] = dv_r[s];
      dsh = CMPW'(dv_r[s].dmag) << (NDIV - 1 - s);
      for (int i = 0; i < 9; i++) begin
        if (CMPW'(dv_r[s].rem[i]) >= dsh) begin
          dv_nxt[s+1].rem[i] = dv_r[s].rem[i] - dsh[REMW-1:0];
          dv_nxt[s+1].quo[i] = {dv_r[s].quo[i][NDIV-2:0], 1'b1};
        end else begin
          dv_nxt[s+1].quo[i] = {dv_r[s].quo[i][NDIV-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s <= NDIV; s++) begin
      if (en[4+s]) begin
        dv_r[s] <= dv_nxt[s];
      end
    end
  end

  // Sign, saturate, zero out singular matrices.
  always_comb begin
    logic signed [15:0] b [9];
    logic [8:0]         clip;
    logic [NDIV-1:0]    q;
    for (int i = 0; i < 9; i++) begin
      q = dv_r[NDIV].quo[i];
      clip[i] = 1'b0;
      if (dv_r[NDIV].neg[i]) begin
        if (q > NDIV'(32768)) begin
          b[i] = 16'sh8000;
          clip[i] = 1'b1;
        end else begin
          b[i] = 16'(-q);
        end
      end else begin
        if (q > NDIV'(32767)) begin
          b[i] = 16'sh7fff;
          clip[i] = 1'b1;
        end else begin
          b[i] = q[15:0];
        end
      end
      if (dv_r[NDIV].sing) begin
        b[i] = '0;
      end
    end
    out_nxt.b11 = b[0];  out_nxt.b12 = b[1];  out_nxt.b13 = b[2];
    out_nxt.b21 = b[3];  out_nxt.b22 = b[4];  out_nxt.b23 = b[5];
    out_nxt.b31 = b[6];  out_nxt.b32 = b[7];  out_nxt.b33 = b[8];
    out_nxt.singular = dv_r[NDIV].sing;
    out_nxt.clipped  = !dv_r[NDIV].sing && (|clip);
  end

  always_ff @(posedge clk) begin
    if (en[NST-1]) begin
      out_r <= out_nxt;
    end
  end

endmodule
